// ----- hdl/bb3_pkg.sv -----
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and helpers for the 3x3 edge-aware box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int BB3_MAX_WIDTH = 1024;

  // configuration register indexes
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

  localparam int SUM_W = 12;  // 9 * 255 fits
  localparam int CNT_W = 4;   // neighbor count 1..9

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       pad;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  // floor(2^16 / (2n)) for the rounded mean
  function automatic logic [15:0] recip_2n(input logic [CNT_W-1:0] n);
    logic [15:0] r;
    case (n)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10922;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6553;
      4'd6:    r = 16'd5461;
      4'd7:    r = 16'd4681;
      4'd8:    r = 16'd4096;
      4'd9:    r = 16'd3640;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/bb3_ram.sv -----
// ----------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bb3_div.sv -----
// ----------------------------------------------------------------------------
// bb3_div
// Rounded mean (2*sum + n) / (2n) per channel, two stages, reciprocal based.
// ----------------------------------------------------------------------------
module bb3_div
  import bb3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sum_t             sum,
  input  logic [CNT_W-1:0] n,
  output logic [7:0]       q_red,
  output logic [7:0]       q_green,
  output logic [7:0]       q_blue,
  output logic             done
);

  localparam int T_W = SUM_W + 1;

  logic [T_W-1:0]   t_nxt [3];
  logic [T_W-1:0]   t_r   [3];
  logic [T_W-1:0]   qe_nxt[3];
  logic [T_W-1:0]   qe_r  [3];
  logic [7:0]       q_nxt [3];
  logic [7:0]       q_r   [3];
  logic [4:0]       d_r;
  logic [15:0]      rc;
  logic [SUM_W-1:0] s_in[3];
  logic             v1_r, done_r;

  assign s_in[0] = sum.red;
  assign s_in[1] = sum.green;
  assign s_in[2] = sum.blue;
  assign rc      = recip_2n(n);

  always_comb begin
    logic [T_W+15:0] prod;
    logic [T_W+4:0]  qd;
    logic [T_W+4:0]  rem;
    logic [T_W-1:0]  q;
    for (int i = 0; i < 3; i++) begin
      t_nxt[i]  = {s_in[i], 1'b0} + T_W'(n);
      prod      = (T_W+16)'(t_nxt[i]) * (T_W+16)'(rc);
      qe_nxt[i] = prod[T_W+15:16];
      // estimate is exact or one low
      qd        = (T_W+5)'(qe_r[i]) * (T_W+5)'(d_r);
      rem       = (T_W+5)'(t_r[i]) - qd;
      q         = (rem >= (T_W+5)'(d_r)) ? qe_r[i] + 1'b1 : qe_r[i];
      q_nxt[i]  = (q > T_W'(255)) ? 8'd255 : q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r  <= t_nxt;
      qe_r <= qe_nxt;
      d_r  <= {n, 1'b0};
    end
    if (v1_r) begin
      q_r <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  assign q_red   = q_r[0];
  assign q_green = q_r[1];
  assign q_blue  = q_r[2];
  assign done    = done_r;

endmodule

// ----- hdl/box_blur_3x3_edge_aware.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// Streaming 3x3 box blur over RGB pixels, mean of in-frame neighbors only.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each result is the per-channel mean of the
// in-frame 3x3 neighbors of one pixel (4 at a corner, 6 on an edge, 9
// inside), rounded half up. Results lag the input by one row plus one pixel;
// after the last pixel, send pad items to drain the final row. A pad item
// during the frame is dropped. frame_end marks the last result of a frame,
// after which the next item starts a new frame. Writing frame_width or
// frame_height abandons any frame in progress. An item that yields a result
// keeps in_stall high, so that no new item is taken, through the nine
// neighbor reads through the single read port of the line store, the
// two-stage divide and any wait of the result register on out_stall.
// Line store is one RAM of four rows of MAX_WIDTH (rounded up to a power of
// two) pixels; it needs no clearing.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = BB3_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);   // column index bits
  localparam int WW  = CW + 1;              // effective width bits
  localparam int TW  = WW + 16;             // pixels per frame
  localparam int ICW = TW + 1;              // items per frame incl. drain
  localparam int AW  = CW + 2;              // line store address
  localparam int RAM_DEPTH = 4 << CW;

  // sequencer
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_GO   = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [10:0]      fw_r;
  logic [15:0]      fh_r;
  logic [WW-1:0]    w_eff;
  logic [15:0]      h_eff;
  logic [TW-1:0]    total_r;
  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [15:0]      in_row_r, in_row_nxt;
  logic [CW-1:0]    out_col_r, out_col_nxt;
  logic [15:0]      out_row_r, out_row_nxt;
  logic [ICW-1:0]   item_cnt_r, item_cnt_nxt;
  logic [1:0]       rsel_r, rsel_nxt, csel_r, csel_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  sum_t             sum_r, sum_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             accept, in_frame, ram_we, nb_ok, last, out_load;
  logic [AW-1:0]    waddr, raddr;
  logic [23:0]      rdata;
  logic [CW-1:0]    nb_col;
  logic [1:0]       nb_row;
  logic [7:0]       q_red, q_green, q_blue;
  logic             div_done;

  // effective geometry
  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (13'(fw_r) > 13'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    h_eff = (fh_r == '0) ? 16'd1 : fh_r;
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_frame = (item_cnt_r < ICW'(total_r));
  assign ram_we   = accept && in_frame && !in_data.pad;
  assign waddr    = {in_row_r[1:0], in_col_r};

  // neighbor under the read pointer
  always_comb begin
    nb_ok = 1'b1;
    if (rsel_r == 2'd0 && out_row_r == '0) nb_ok = 1'b0;
    if (rsel_r == 2'd2 && (17'(out_row_r) + 17'd1 >= 17'(h_eff))) nb_ok = 1'b0;
    if (csel_r == 2'd0 && out_col_r == '0) nb_ok = 1'b0;
    if (csel_r == 2'd2 && (WW'(out_col_r) + WW'(1) >= w_eff)) nb_ok = 1'b0;
    nb_row = out_row_r[1:0] + rsel_r - 2'd1;
    nb_col = out_col_r + CW'(csel_r) - CW'(1);
  end
  assign raddr = {nb_row, nb_col};

  assign last = (17'(out_row_r) + 17'd1 >= 17'(h_eff)) &&
                (WW'(out_col_r) + WW'(1) >= w_eff);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    item_cnt_nxt  = item_cnt_r;
    rsel_nxt      = rsel_r;
    csel_nxt      = csel_r;
    rd_pend_nxt   = 1'b0;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    // accumulate the neighbor read issued last cycle
    if (rd_pend_r) begin
      sum_nxt.red   = sum_r.red   + SUM_W'(rdata[23:16]);
      sum_nxt.green = sum_r.green + SUM_W'(rdata[15:8]);
      sum_nxt.blue  = sum_r.blue  + SUM_W'(rdata[7:0]);
      n_nxt         = n_r + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && !(in_frame && in_data.pad)) begin
          if (in_frame) begin
            if (WW'(in_col_r) + WW'(1) >= w_eff) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + 1'b1;
            end else begin
              in_col_nxt = in_col_r + 1'b1;
            end
          end
          item_cnt_nxt = item_cnt_r + 1'b1;
          if (item_cnt_nxt >= ICW'(w_eff) + ICW'(2)) begin
            state_nxt = ST_RD;
            rsel_nxt  = '0;
            csel_nxt  = '0;
            sum_nxt   = '0;
            n_nxt     = '0;
          end
        end
      end
      ST_RD: begin
        rd_pend_nxt = nb_ok;
        if (csel_r == 2'd2) begin
          csel_nxt = '0;
          rsel_nxt = rsel_r + 1'b1;
          if (rsel_r == 2'd2) state_nxt = ST_ACC;
        end else begin
          csel_nxt = csel_r + 1'b1;
        end
      end
      ST_ACC:  state_nxt = ST_GO;
      ST_GO:   state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_red   = q_red;
          out_data_nxt.out_green = q_green;
          out_data_nxt.out_blue  = q_blue;
          out_data_nxt.frame_end = last;
          state_nxt              = ST_IDLE;
          if (last) begin
            in_col_nxt   = '0;
            in_row_nxt   = '0;
            out_col_nxt  = '0;
            out_row_nxt  = '0;
            item_cnt_nxt = '0;
          end else if (WW'(out_col_r) + WW'(1) >= w_eff) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + 1'b1;
          end else begin
            out_col_nxt = out_col_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // geometry write abandons the frame
    if (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      item_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fw_r        <= FRAME_WIDTH_RST;
      fh_r        <= FRAME_HEIGHT_RST;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      item_cnt_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      item_cnt_r  <= item_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_FRAME_WIDTH)  fw_r <= cfg_wdata[10:0];
      if (cfg_we && cfg_index == CFG_FRAME_HEIGHT) fh_r <= cfg_wdata;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    total_r    <= TW'(w_eff) * TW'(h_eff);
    rsel_r     <= rsel_nxt;
    csel_r     <= csel_nxt;
    sum_r      <= sum_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

  bb3_ram #(
    .WIDTH (24),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({in_data.in_red, in_data.in_green, in_data.in_blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  bb3_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_GO),
    .sum     (sum_r),
    .n       (n_r),
    .q_red   (q_red),
    .q_green (q_green),
    .q_blue  (q_blue),
    .done    (div_done)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // the center pixel is always in frame, so a divide never starts with no neighbors
  a_n_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GO) |-> (n_r != '0))
    else $error("neighbor count zero at divide start");

  // divider completes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divide finished outside wait state");

  // a frame-end result leaves all frame counters cleared
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last) |=> (item_cnt_r == '0 && out_row_r == '0 && out_col_r == '0))
    else $error("counters not cleared after frame end");
`endif

endmodule
